>>> rtl/ipfc_pkg.sv
// Package for the IPv4 flow counter: widths, frame constants, count limits, status codes, sequencer states.
// No dependencies.
`default_nettype none
package ipfc_pkg;
    localparam int FlowEntries = 64;
    localparam int SlotW = 6;
    localparam int CountW = 7;
    localparam logic [5:0] MinFrame = 6'd38;
    localparam logic [15:0] EtherIpv4 = 16'h0800;
    localparam logic [7:0] ProtoTcp = 8'd6;
    localparam logic [7:0] ProtoUdp = 8'd17;
    localparam logic [31:0] PktMax = 32'hFFFF_FFFF;
    localparam logic [47:0] BytesMax = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] StNew = 3'd0;
    localparam logic [2:0] StExisting = 3'd1;
    localparam logic [2:0] StIgnored = 3'd2;
    localparam logic [2:0] StFull = 3'd3;
    localparam logic [2:0] StShort = 3'd4;
    localparam logic [2:0] StRead = 3'd5;
    localparam logic [2:0] StEmpty = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_UPDATE, S_ALLOC, S_READ, S_OUT
    } t_state;
endpackage
`default_nettype wire

>>> rtl/ipfc_if.sv
// Valid/ready channel interfaces for the IPv4 flow counter.
// No dependencies.
`default_nettype none
interface ipfc_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] wire_length;
    logic [5:0]  entry_index;
    modport source (output valid, req_type, data_byte, last_byte, wire_length,
                    entry_index, input ready);
    modport sink (input valid, req_type, data_byte, last_byte, wire_length,
                  entry_index, output ready);
endinterface

interface ipfc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] src_port_out;
    logic [15:0] dst_port_out;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
    logic [6:0]  flows_in_use;
    modport source (output valid, status, slot, src_address, dst_address,
                    src_port_out, dst_port_out, packet_total, byte_total,
                    flows_in_use, input ready);
    modport sink (input valid, status, slot, src_address, dst_address,
                  src_port_out, dst_port_out, packet_total, byte_total,
                  flows_in_use, output ready);
endinterface
`default_nettype wire

>>> rtl/ipv4_flow_counter.sv
// Top level of the IPv4 flow counter: header capture, slot-walking flow search.
// Depends on ipfc_pkg and the channel interfaces in ipfc_if.sv.
`default_nettype none
// A middle frame byte is accepted and gives no result. A final byte
// of a counted frame walks the flow table through a single key comparator that
// reads one memory entry at a time; each slot is fetched and then compared.
// A hit then passes through the update state and the output state. A miss
// walks all 64 slots, then steps through the valid bits one a cycle to the
// lowest free slot and allocates the flow there; if none is free, the table is
// full. Short or ignored frames go straight to the output state, and reads
// go through the read state first. The block holds one item at a time:
// ready is low while a frame end or read is in progress and while a result
// waits in the output register, and it returns the cycle after the result is
// taken. Table entries live in memory without reset; only the valid bits and
// the occupancy count are cleared.
module ipv4_flow_counter (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ipfc_in_if.sink  i_in,
    ipfc_out_if.source o_out
);
    // memories: keys and counts, one write port and one read port, registered read
    logic [95:0] r_key_mem [ipfc_pkg::FlowEntries];
    logic [79:0] r_cnt_mem [ipfc_pkg::FlowEntries];
    logic [95:0] r_key_rd;
    logic [79:0] r_cnt_rd;

    logic [ipfc_pkg::FlowEntries-1:0] r_valid, n_valid;
    logic [6:0]  r_used, n_used;
    ipfc_pkg::t_state r_state, n_state;

    // capture state
    logic [5:0]  r_pos;
    logic [15:0] r_ether;
    logic [3:0]  r_ver;
    logic [7:0]  r_proto;
    logic [31:0] r_src, r_dst, r_ports;
    logic [15:0] r_len;

    logic [5:0]  r_idx, n_idx;
    logic        r_rd_wait, n_rd_wait;
    logic        n_mem_we;
    logic        n_cnt_we;
    logic [79:0] n_wr_cnt;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [2:0]  r_status, n_status;
    logic [5:0]  r_slot, n_slot;
    logic        r_with, n_with;

    wire in_acc = i_in.valid && i_in.ready;
    wire out_acc = o_out.valid && o_out.ready;

    assign i_in.ready = (r_state == ipfc_pkg::S_IDLE) && !r_ovalid;

    // capture header bytes at fixed offsets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_ether <= '0; r_ver <= '0; r_proto <= '0;
            r_src <= '0; r_dst <= '0; r_ports <= '0;
        end else if (in_acc && !i_in.req_type) begin
            if (i_in.last_byte) begin
                r_pos <= '0; r_ether <= '0; r_ver <= '0; r_proto <= '0;
                r_src <= '0; r_dst <= '0; r_ports <= '0;
            end else begin
                if (r_pos < ipfc_pkg::MinFrame) r_pos <= r_pos + 6'd1;
                if (r_pos == 6'd12 || r_pos == 6'd13)
                    r_ether <= {r_ether[7:0], i_in.data_byte};
                if (r_pos == 6'd14) r_ver <= i_in.data_byte[7:4];
                if (r_pos == 6'd23) r_proto <= i_in.data_byte;
                if (r_pos >= 6'd26 && r_pos <= 6'd29)
                    r_src <= {r_src[23:0], i_in.data_byte};
                if (r_pos >= 6'd30 && r_pos <= 6'd33)
                    r_dst <= {r_dst[23:0], i_in.data_byte};
                if (r_pos >= 6'd34 && r_pos <= 6'd37)
                    r_ports <= {r_ports[23:0], i_in.data_byte};
            end
        end
    end

    // key of the frame being finished, including its final byte
    logic [31:0] r_k_src, r_k_dst, r_k_ports;
    logic [5:0]  w_pos;
    logic        w_ok;
    always_comb begin
        w_pos = (r_pos < ipfc_pkg::MinFrame) ? r_pos + 6'd1 : r_pos;
        w_ok = (r_ether == ipfc_pkg::EtherIpv4) && (r_ver == 4'd4)
            && (r_proto == ipfc_pkg::ProtoTcp || r_proto == ipfc_pkg::ProtoUdp);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_k_src <= r_src;
            r_k_dst <= r_dst;
            r_k_ports <= (r_pos >= 6'd34 && r_pos <= 6'd37)
                ? {r_ports[23:0], i_in.data_byte} : r_ports;
            r_len <= i_in.wire_length;
        end
    end

    wire [95:0] w_key = {r_k_src, r_k_dst, r_k_ports};

    // write at the end of the update or allocate cycle so the read in the
    // output cycle already sees the new entry
    always_ff @(posedge i_clk) begin
        if (n_mem_we) r_key_mem[r_idx] <= w_key;
        if (n_cnt_we) r_cnt_mem[r_idx] <= n_wr_cnt;
        r_key_rd <= r_key_mem[n_idx];
        r_cnt_rd <= r_cnt_mem[n_idx];
    end

    // saturating count update from the entry just read
    logic [31:0] w_pk;
    logic [48:0] w_by;
    always_comb begin
        w_pk = (r_cnt_rd[79:48] < ipfc_pkg::PktMax) ? r_cnt_rd[79:48] + 32'd1
                                                     : r_cnt_rd[79:48];
        w_by = {1'b0, r_cnt_rd[47:0]} + {33'd0, r_len};
        if (w_by[48]) w_by = {1'b0, ipfc_pkg::BytesMax};
    end

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_rd_wait = 1'b0;
        n_valid = r_valid; n_used = r_used;
        n_mem_we = 1'b0; n_cnt_we = 1'b0; n_wr_cnt = '0;
        n_ovalid = r_ovalid; n_status = r_status; n_slot = r_slot; n_with = r_with;
        if (out_acc) n_ovalid = 1'b0;
        case (r_state)
            ipfc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_in.req_type) begin
                        n_idx = i_in.entry_index;
                        n_slot = i_in.entry_index;
                        n_state = ipfc_pkg::S_READ;
                    end else if (i_in.last_byte) begin
                        n_slot = '0; n_with = 1'b0;
                        if (w_pos < ipfc_pkg::MinFrame) begin
                            n_status = ipfc_pkg::StShort;
                            n_state = ipfc_pkg::S_OUT;
                        end else if (!w_ok) begin
                            n_status = ipfc_pkg::StIgnored;
                            n_state = ipfc_pkg::S_OUT;
                        end else begin
                            n_idx = '0; n_rd_wait = 1'b1;
                            n_state = ipfc_pkg::S_SEARCH;
                        end
                    end
                end
            end
            ipfc_pkg::S_SEARCH: begin
                // compare the entry read last cycle; advance one slot
                if (r_rd_wait) begin
                    n_rd_wait = 1'b0;
                end else if (r_valid[r_idx] && r_key_rd == w_key) begin
                    n_state = ipfc_pkg::S_UPDATE;
                end else if (r_idx == 6'(ipfc_pkg::FlowEntries - 1)) begin
                    n_idx = '0;
                    n_state = ipfc_pkg::S_ALLOC;
                end else begin
                    n_idx = r_idx + 6'd1; n_rd_wait = 1'b1;
                end
            end
            ipfc_pkg::S_UPDATE: begin
                n_cnt_we = 1'b1;
                n_wr_cnt = {w_pk, w_by[47:0]};
                n_status = ipfc_pkg::StExisting; n_slot = r_idx; n_with = 1'b1;
                n_state = ipfc_pkg::S_OUT;
            end
            ipfc_pkg::S_ALLOC: begin
                // walk valid bits to the lowest free slot
                if (!r_valid[r_idx]) begin
                    n_valid[r_idx] = 1'b1; n_used = r_used + 7'd1;
                    n_mem_we = 1'b1; n_cnt_we = 1'b1;
                    n_wr_cnt = {32'd1, 32'd0, r_len};
                    n_status = ipfc_pkg::StNew; n_slot = r_idx; n_with = 1'b1;
                    n_state = ipfc_pkg::S_OUT;
                end else if (r_idx == 6'(ipfc_pkg::FlowEntries - 1)) begin
                    n_status = ipfc_pkg::StFull; n_slot = '0; n_with = 1'b0;
                    n_state = ipfc_pkg::S_OUT;
                end else begin
                    n_idx = r_idx + 6'd1;
                end
            end
            ipfc_pkg::S_READ: begin
                n_with = r_valid[r_idx];
                n_status = r_valid[r_idx] ? ipfc_pkg::StRead : ipfc_pkg::StEmpty;
                n_state = ipfc_pkg::S_OUT;
            end
            ipfc_pkg::S_OUT: begin
                // wait for the memory read/write to settle, then present
                n_ovalid = 1'b1;
                n_state = ipfc_pkg::S_IDLE;
            end
            default: n_state = ipfc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipfc_pkg::S_IDLE;
            r_valid <= '0;
            r_used <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_used <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_rd_wait <= n_rd_wait;
        r_status <= n_status; r_slot <= n_slot; r_with <= n_with;
    end

    // entry fields come from the memory read data of the presented slot;
    // r_idx holds that slot and the write has landed by the time valid rises
    assign o_out.valid = r_ovalid;
    assign o_out.status = r_status;
    assign o_out.slot = r_slot;
    assign o_out.src_address = r_with ? r_key_rd[95:64] : '0;
    assign o_out.dst_address = r_with ? r_key_rd[63:32] : '0;
    assign o_out.src_port_out = r_with ? r_key_rd[31:16] : '0;
    assign o_out.dst_port_out = r_with ? r_key_rd[15:0] : '0;
    assign o_out.packet_total = r_with ? r_cnt_rd[79:48] : '0;
    assign o_out.byte_total = r_with ? r_cnt_rd[47:0] : '0;
    assign o_out.flows_in_use = r_used;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ipfc_pkg::S_IDLE) |-> !i_in.ready)
        else $error("input accepted while busy");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= 7'(ipfc_pkg::FlowEntries))
        else $error("occupancy over table size");
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ipfc_pkg::S_ALLOC && !r_valid[r_idx]) |=> r_used == $past(r_used) + 7'd1)
        else $error("allocation did not count");
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for ipv4_flow_counter: frame bytes and slot reads in,
// flow results out, compared against an in-bench flow table predictor.
// Depends on ipfc_pkg, the channel interfaces in ipfc_if.sv and the RTL top.
`timescale 1ns / 100ps
module tb;
    localparam logic ReqByte = 1'b0;
    localparam logic ReqRead = 1'b1;
    localparam int QuietLimit = 4000;
    localparam int ErrShown = 10;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wire_length;
        logic [5:0]  entry_index;
    } t_flow_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [6:0]  flows_in_use;
    } t_flow_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #2 i_clk = ~i_clk;

    ipfc_in_if  in_ch ();
    ipfc_out_if out_ch ();

    ipv4_flow_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: header capture and the flow table.
    logic [5:0]  frame_pos;
    logic [15:0] cap_ether;
    logic [3:0]  cap_version;
    logic [7:0]  cap_proto;
    logic [31:0] cap_src;
    logic [31:0] cap_dst;
    logic [31:0] cap_ports;
    logic [31:0] flow_src [ipfc_pkg::FlowEntries];
    logic [31:0] flow_dst [ipfc_pkg::FlowEntries];
    logic [31:0] flow_ports [ipfc_pkg::FlowEntries];
    logic [31:0] flow_packets [ipfc_pkg::FlowEntries];
    logic [47:0] flow_bytes [ipfc_pkg::FlowEntries];
    logic        flow_live [ipfc_pkg::FlowEntries];
    logic [6:0]  flows_used;

    t_flow_result pending_results[$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  frames_sent = 0;
    int  reads_sent = 0;
    int  full_seen = 0;
    bit  idle_off = 1'b0;
    int  quiet_cycles = 0;
    logic [31:0] key_src [8];
    logic [31:0] key_dst [8];
    logic [31:0] key_ports [8];

    function automatic void clear_capture();
        frame_pos = '0;
        cap_ether = '0;
        cap_version = '0;
        cap_proto = '0;
        cap_src = '0;
        cap_dst = '0;
        cap_ports = '0;
    endfunction

    function automatic t_flow_result flow_result(logic [2:0] st, int s, bit with_entry);
        t_flow_result r;
        r = '0;
        r.status = st;
        r.slot = s[5:0];
        if (with_entry) begin
            r.src_address = flow_src[s];
            r.dst_address = flow_dst[s];
            r.src_port = flow_ports[s][31:16];
            r.dst_port = flow_ports[s][15:0];
            r.packets = flow_packets[s];
            r.bytes = flow_bytes[s];
        end
        r.flows_in_use = flows_used;
        return r;
    endfunction

    // Count one finished frame into the table.
    function automatic t_flow_result count_frame(logic [15:0] len);
        if (frame_pos < ipfc_pkg::MinFrame) return flow_result(ipfc_pkg::StShort, 0, 1'b0);
        if (cap_ether != ipfc_pkg::EtherIpv4 || cap_version != 4'd4 ||
            (cap_proto != ipfc_pkg::ProtoTcp && cap_proto != ipfc_pkg::ProtoUdp))
            return flow_result(ipfc_pkg::StIgnored, 0, 1'b0);
        for (int i = 0; i < ipfc_pkg::FlowEntries; i++) begin
            if (flow_live[i] && flow_src[i] == cap_src && flow_dst[i] == cap_dst &&
                flow_ports[i] == cap_ports) begin
                if (flow_packets[i] != ipfc_pkg::PktMax) flow_packets[i]++;
                if (flow_bytes[i] > ipfc_pkg::BytesMax - {32'd0, len})
                    flow_bytes[i] = ipfc_pkg::BytesMax;
                else flow_bytes[i] = flow_bytes[i] + {32'd0, len};
                return flow_result(ipfc_pkg::StExisting, i, 1'b1);
            end
        end
        for (int i = 0; i < ipfc_pkg::FlowEntries; i++) begin
            if (!flow_live[i]) begin
                flow_live[i] = 1'b1;
                flow_src[i] = cap_src;
                flow_dst[i] = cap_dst;
                flow_ports[i] = cap_ports;
                flow_packets[i] = 32'd1;
                flow_bytes[i] = {32'd0, len};
                flows_used++;
                return flow_result(ipfc_pkg::StNew, i, 1'b1);
            end
        end
        full_seen++;
        return flow_result(ipfc_pkg::StFull, 0, 1'b0);
    endfunction

    // Advance the predictor by one accepted item; queue the result it causes.
    function automatic void predict_flow(t_flow_req r);
        if (r.req_type == ReqRead) begin
            if (flow_live[r.entry_index])
                pending_results.push_back(
                    flow_result(ipfc_pkg::StRead, int'(r.entry_index), 1'b1));
            else
                pending_results.push_back(
                    flow_result(ipfc_pkg::StEmpty, int'(r.entry_index), 1'b0));
            return;
        end
        case (frame_pos)
            6'd12, 6'd13: cap_ether = {cap_ether[7:0], r.data_byte};
            6'd14: cap_version = r.data_byte[7:4];
            6'd23: cap_proto = r.data_byte;
            6'd26, 6'd27, 6'd28, 6'd29: cap_src = {cap_src[23:0], r.data_byte};
            6'd30, 6'd31, 6'd32, 6'd33: cap_dst = {cap_dst[23:0], r.data_byte};
            6'd34, 6'd35, 6'd36, 6'd37: cap_ports = {cap_ports[23:0], r.data_byte};
            default: ;
        endcase
        if (frame_pos < ipfc_pkg::MinFrame) frame_pos++;
        if (r.last_byte) begin
            pending_results.push_back(count_frame(r.wire_length));
            clear_capture();
        end
    endfunction

    // Drive one item after a random gap; keep valid high when the next gap is zero.
    task automatic send_item(t_flow_req r);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= r.req_type;
        in_ch.data_byte <= r.data_byte;
        in_ch.last_byte <= r.last_byte;
        in_ch.wire_length <= r.wire_length;
        in_ch.entry_index <= r.entry_index;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predict_flow(r);
        items_sent++;
        if (r.req_type == ReqRead) reads_sent++;
        else if (r.last_byte) frames_sent++;
    endtask

    task automatic read_slot(logic [5:0] idx);
        t_flow_req r;
        r = '0;
        r.req_type = ReqRead;
        r.data_byte = 8'($urandom);
        r.last_byte = 1'($urandom);
        r.wire_length = 16'($urandom);
        r.entry_index = idx;
        send_item(r);
    endtask

    // Send a whole frame; reads are slipped in between bytes at read_pct percent.
    task automatic send_frame(logic [15:0] ether, logic [3:0] ver, logic [7:0] proto,
                              logic [31:0] src, logic [31:0] dst, logic [31:0] ports,
                              int nbytes, logic [15:0] wlen, int read_pct);
        t_flow_req r;
        for (int p = 0; p < nbytes; p++) begin
            if ($urandom_range(0, 99) < read_pct) read_slot(6'($urandom));
            r = '0;
            r.req_type = ReqByte;
            r.data_byte = 8'($urandom);
            case (p)
                12: r.data_byte = ether[15:8];
                13: r.data_byte = ether[7:0];
                14: r.data_byte = {ver, 4'($urandom)};
                23: r.data_byte = proto;
                26, 27, 28, 29: r.data_byte = src[8*(29-p) +: 8];
                30, 31, 32, 33: r.data_byte = dst[8*(33-p) +: 8];
                34, 35, 36, 37: r.data_byte = ports[8*(37-p) +: 8];
                default: ;
            endcase
            r.last_byte = (p == nbytes - 1);
            r.wire_length = 16'($urandom);
            if (r.last_byte) r.wire_length = wlen;
            r.entry_index = 6'($urandom);
            send_item(r);
        end
    endtask

    task automatic test_directed();
        read_slot(6'd0);
        read_slot(6'd63);
        // Short frames: one byte, and one byte below the minimum with a good header.
        send_frame(ipfc_pkg::EtherIpv4, 4'd4, ipfc_pkg::ProtoTcp, key_src[0], key_dst[0],
                   key_ports[0], 1, 16'hFFFF, 0);
        send_frame(ipfc_pkg::EtherIpv4, 4'd4, ipfc_pkg::ProtoTcp, key_src[0], key_dst[0],
                   key_ports[0], 37, 16'd37, 0);
        // New flow, then the same key over TCP and over UDP.
        send_frame(ipfc_pkg::EtherIpv4, 4'd4, ipfc_pkg::ProtoTcp, key_src[0], key_dst[0],
                   key_ports[0], 38, 16'd0, 0);
        send_frame(ipfc_pkg::EtherIpv4, 4'd4, ipfc_pkg::ProtoTcp, key_src[0], key_dst[0],
                   key_ports[0], 60, 16'hFFFF, 0);
        send_frame(ipfc_pkg::EtherIpv4, 4'd4, ipfc_pkg::ProtoUdp, key_src[0], key_dst[0],
                   key_ports[0], 38, 16'd1, 10);
        // Frames that are not IPv4 TCP/UDP, then a UDP frame on the same key.
        send_frame(16'h86DD, 4'd4, ipfc_pkg::ProtoTcp, key_src[1], key_dst[1],
                   key_ports[1], 38, 16'd64, 0);
        send_frame(ipfc_pkg::EtherIpv4, 4'd6, ipfc_pkg::ProtoUdp, key_src[1], key_dst[1],
                   key_ports[1], 38, 16'd64, 0);
        send_frame(ipfc_pkg::EtherIpv4, 4'd4, 8'd1, key_src[1], key_dst[1],
                   key_ports[1], 40, 16'd64, 0);
        send_frame(ipfc_pkg::EtherIpv4, 4'd4, ipfc_pkg::ProtoUdp, key_src[1], key_dst[1],
                   key_ports[1], 38, 16'd1500, 0);
        read_slot(6'd0);
        read_slot(6'd1);
        read_slot(6'd2);
    endtask

    // Mostly well-formed frames over a small key pool, with noise, short frames,
    // slot reads and now and then a fresh key.
    task automatic test_random_traffic(int n_items);
        int stop_at, pick, kind, len;
        logic [15:0] ether;
        logic [3:0]  ver;
        logic [7:0]  proto;
        logic [31:0] src, dst, ports;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            idle_off = ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 7);
            kind = $urandom_range(0, 99);
            ether = ipfc_pkg::EtherIpv4;
            ver = 4'd4;
            proto = $urandom_range(0, 1) ? ipfc_pkg::ProtoTcp : ipfc_pkg::ProtoUdp;
            len = $urandom_range(38, 46);
            src = key_src[pick];
            dst = key_dst[pick];
            ports = key_ports[pick];
            if (kind < 8) ether = 16'($urandom);
            else if (kind < 14) ver = 4'($urandom);
            else if (kind < 20) proto = 8'($urandom);
            else if (kind < 28) len = $urandom_range(1, 37);
            else if (kind >= 88 && kind < 95) begin
                src = $urandom;
                dst = $urandom;
                ports = $urandom;
            end
            if (kind >= 95) read_slot(6'($urandom));
            else send_frame(ether, ver, proto, src, dst, ports, len, 16'($urandom), 3);
        end
        idle_off = 1'b0;
    endtask

    // Read back every slot, occupied and empty.
    task automatic test_table_sweep();
        for (int i = 0; i < ipfc_pkg::FlowEntries; i++) read_slot(6'(i));
    endtask

    // Result side: random stalls, compare each result with the oldest expectation.
    initial begin : result_check
        int stall;
        t_flow_result got;
        t_flow_result want;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_off ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            got = {out_ch.status, out_ch.slot, out_ch.src_address, out_ch.dst_address,
                   out_ch.src_port_out, out_ch.dst_port_out, out_ch.packet_total,
                   out_ch.byte_total, out_ch.flows_in_use};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= ErrShown) $display("unexpected result %h", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= ErrShown) begin
                        $display("mismatch: exp st=%0d slot=%0d %h %h %h %h pk=%0d by=%0d u=%0d",
                                 want.status, want.slot, want.src_address, want.dst_address,
                                 want.src_port, want.dst_port, want.packets, want.bytes,
                                 want.flows_in_use);
                        $display("          got st=%0d slot=%0d %h %h %h %h pk=%0d by=%0d u=%0d",
                                 got.status, got.slot, got.src_address, got.dst_address,
                                 got.src_port, got.dst_port, got.packets, got.bytes,
                                 got.flows_in_use);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QuietLimit) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.req_type <= ReqByte;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;
        in_ch.wire_length <= '0;
        in_ch.entry_index <= '0;
        clear_capture();
        flows_used = '0;
        for (int i = 0; i < ipfc_pkg::FlowEntries; i++) begin
            flow_live[i] = 1'b0;
            flow_src[i] = '0;
            flow_dst[i] = '0;
            flow_ports[i] = '0;
            flow_packets[i] = '0;
            flow_bytes[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            key_src[i] = $urandom;
            key_dst[i] = $urandom;
            key_ports[i] = $urandom;
        end
        key_src[7] = '1;
        key_dst[7] = '1;
        key_ports[7] = '1;
        key_src[6] = '0;
        key_dst[6] = '0;
        key_ports[6] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(360);
        test_table_sweep();
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        mismatches += pending_results.size();
        $display("covered %0d items: %0d frames, %0d slot reads, %0d table-full drops",
                 items_sent, frames_sent, reads_sent, full_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/ipfc_pkg.sv
rtl/ipfc_if.sv
rtl/ipv4_flow_counter.sv
tb/tb.sv
